// ===== design/mse_pkg.sv =====
// mse_pkg: shared constants and types for the merge sort engine
// no dependencies; imported by merge_sort_engine, mse_checker and tb_top
package mse_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned DEFAULT_MAX_ITEMS = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MRD,
    ST_MCMP,
    ST_ERD,
    ST_EOUT
  } mse_state_e;

endpackage

// ===== design/merge_sort_engine.sv =====
// merge_sort_engine: list loader, bottom-up merge sorter and result streamer
// depends on mse_pkg
//
// The block collects a list of signed 32-bit values, one per input transaction, until a
// transaction with last_i set arrives (that value is kept too). Values beyond MAX_ITEMS are
// discarded, and every result of that list then carries dropped_o. The list is sorted into
// ascending signed order and streamed out one value per output transaction, final_res_o
// marking the last one. While a list is sorted or streamed, in_ready_o stays low; it rises
// again the cycle after the final result is taken. For a list of n values, loading stores
// each accepted value that fits; sorting takes ceil(log2 n) merge passes over the ping-pong
// buffer memories, each merge step reading both run heads and then comparing and writing
// back; streaming reads each result and then offers it until it is taken. Both buffers
// power up undefined and need no clearing.
module merge_sort_engine
  import mse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input list channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  // sorted result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     final_res_o,
  output logic                     dropped_o
);

  // address width, count width (holds MAX_ITEMS itself), and a width for run-bound sums
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = CW + 2;

  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);

  // control state
  mse_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;   // values stored in the current load
  logic          ovf_q, ovf_d;   // a value was discarded in the current load
  logic [CW-1:0] n_q, n_d;       // list length being sorted / streamed
  logic [CW-1:0] w_q, w_d;       // run width of the current merge pass
  logic [CW-1:0] i_q, i_d;       // head of the first run
  logic [CW-1:0] j_q, j_d;       // head of the second run
  logic [CW-1:0] mid_q, mid_d;   // end of the first run
  logic [CW-1:0] hi_q, hi_d;     // end of the second run
  logic [CW-1:0] k_q, k_d;       // write position in the destination buffer
  logic [CW-1:0] e_q, e_d;       // stream position
  logic          src_q, src_d;   // buffer holding the current runs

  // ping-pong buffers, two read ports each, registered read data
  logic signed [DATA_W-1:0] mem0 [MAX_ITEMS];
  logic signed [DATA_W-1:0] mem1 [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  logic              we0, we1;
  logic [AW-1:0]     waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [CW-1:0]     ridx_a;

  // merge datapath
  logic signed [DATA_W-1:0] head_a, head_b;
  logic                     a_ok, b_ok, take_a;
  logic                     in_fire, out_fire, full, list_end;
  logic [CW-1:0]            n_new;

  // block setup: next pair of runs starting at setup_lo with run width setup_w
  logic [SW-1:0] setup_lo, setup_w, setup_n, sum_mid, sum_hi, new_w;
  logic [CW-1:0] mid_set, hi_set;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_EOUT);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;
  assign full        = (cnt_q == MaxCnt);
  assign n_new       = full ? cnt_q : CW'(cnt_q + 1'b1);
  assign list_end    = (CW'(e_q + 1'b1) == n_q);

  assign head_a = src_q ? rd1a_q : rd0a_q;
  assign head_b = src_q ? rd1b_q : rd0b_q;
  assign a_ok   = (i_q < mid_q);
  assign b_ok   = (j_q < hi_q);
  // strict compare: on equal heads the second run goes first
  assign take_a = a_ok & (~b_ok | (head_a < head_b));

  assign sorted_value_o = head_a;
  assign final_res_o    = list_end;
  assign dropped_o      = ovf_q;

  assign new_w = SW'(w_q) << 1;

  // setup source: first pass after load, next pass, or next block of this pass
  always_comb begin
    if (state_q == ST_LOAD) begin
      setup_lo = '0;
      setup_w  = SW'(1);
      setup_n  = SW'(n_new);
    end else if (hi_q == n_q) begin
      setup_lo = '0;
      setup_w  = new_w;
      setup_n  = SW'(n_q);
    end else begin
      setup_lo = SW'(hi_q);
      setup_w  = SW'(w_q);
      setup_n  = SW'(n_q);
    end
    sum_mid = setup_lo + setup_w;
    sum_hi  = setup_lo + (setup_w << 1);
    mid_set = (sum_mid < setup_n) ? CW'(sum_mid) : CW'(setup_n);
    hi_set  = (sum_hi < setup_n) ? CW'(sum_hi) : CW'(setup_n);
  end

  // read addresses; a head index past the buffer reads entry zero, an exhausted head's data is ignored
  always_comb begin
    ridx_a  = ((state_q == ST_ERD) || (state_q == ST_EOUT)) ? e_q : i_q;
    raddr_a = (ridx_a < MaxCnt) ? AW'(ridx_a) : '0;
    raddr_b = (j_q < MaxCnt) ? AW'(j_q) : '0;
  end

  // write port: load fills buffer 0, merges write the buffer opposite the source
  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = '0;
    wdata = value_i;
    if (state_q == ST_LOAD) begin
      we0   = in_fire & ~full;
      waddr = (cnt_q < MaxCnt) ? AW'(cnt_q) : '0;
    end else if (state_q == ST_MCMP) begin
      we0   = src_q;
      we1   = ~src_q;
      waddr = (k_q < MaxCnt) ? AW'(k_q) : '0;
      wdata = take_a ? head_a : head_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd0a_q <= mem0[raddr_a];
    rd0b_q <= mem0[raddr_b];
    rd1a_q <= mem1[raddr_a];
    rd1b_q <= mem1[raddr_b];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    n_d     = n_q;
    w_d     = w_q;
    i_d     = i_q;
    j_d     = j_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    k_d     = k_q;
    e_d     = e_q;
    src_d   = src_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = CW'(cnt_q + 1'b1);
          end
          if (last_i) begin
            n_d   = n_new;
            src_d = 1'b0;
            e_d   = '0;
            if (n_new == CW'(1)) begin
              // a single value is already sorted
              state_d = ST_ERD;
            end else begin
              w_d     = CW'(1);
              k_d     = '0;
              i_d     = '0;
              mid_d   = mid_set;
              j_d     = mid_set;
              hi_d    = hi_set;
              state_d = ST_MRD;
            end
          end
        end
      end
      ST_MRD: begin
        state_d = ST_MCMP;
      end
      ST_MCMP: begin
        k_d = CW'(k_q + 1'b1);
        if (take_a) begin
          i_d = CW'(i_q + 1'b1);
        end else begin
          j_d = CW'(j_q + 1'b1);
        end
        state_d = ST_MRD;
        if (CW'(k_q + 1'b1) == hi_q) begin
          // block of two runs finished
          i_d   = hi_q;
          mid_d = mid_set;
          j_d   = mid_set;
          hi_d  = hi_set;
          if (hi_q == n_q) begin
            // pass finished, swap buffers
            src_d = ~src_q;
            k_d   = '0;
            i_d   = '0;
            if (new_w >= SW'(n_q)) begin
              e_d     = '0;
              state_d = ST_ERD;
            end else begin
              w_d = CW'(new_w);
            end
          end
        end
      end
      ST_ERD: begin
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_fire) begin
          if (list_end) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            e_d     = CW'(e_q + 1'b1);
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      n_q     <= '0;
      w_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      k_q     <= '0;
      e_q     <= '0;
      src_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      n_q     <= n_d;
      w_q     <= w_d;
      i_q     <= i_d;
      j_q     <= j_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
      e_q     <= e_d;
      src_q   <= src_d;
    end
  end

endmodule

// ===== design/mse_checker.sv =====
// mse_checker: port-level assertions for merge_sort_engine, bound into every merge_sort_engine instance
// depends on mse_pkg
module mse_checker
  import mse_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     last_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] sorted_value_o,
  input logic                     final_res_o,
  input logic                     dropped_o
);

  // loading and streaming never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  // a list end closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("input still ready after last transaction");

  // the final result reopens the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_res_o) |=> (in_ready_o && !out_valid_o))
    else $error("input not ready after final result");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(sorted_value_o) && $stable(final_res_o) && $stable(dropped_o)))
    else $error("stalled result changed");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_i         (last_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sorted_value_o (sorted_value_o),
  .final_res_o    (final_res_o),
  .dropped_o      (dropped_o)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for merge_sort_engine, directed lists followed by random lists
// depends on mse_pkg and merge_sort_engine; the expected sort order comes from a small class

module tb_top
  import mse_pkg::*;
();

  localparam int unsigned CAP          = DEFAULT_MAX_ITEMS;
  localparam int unsigned TARGET_ITEMS = 400;

  typedef logic signed [DATA_W-1:0] word_t;

  // one expected output transaction
  typedef struct {
    word_t value;
    logic  final_res;
    logic  dropped;
  } sorted_word_t;

  // how the values of one random list are drawn
  typedef enum int {
    FILL_ANY,
    FILL_NARROW,
    FILL_EDGES,
    FILL_RISING,
    FILL_FALLING
  } fill_e;

  // collects the current list, sorts it on the closing value and checks the output stream
  class sort_scoreboard;
    word_t        list_q[$];
    bit           overflow;
    sorted_word_t sorted_q[$];
    int           mismatches;
    int           checked;
    int           lists_done;
    int           dropped_lists;

    function void take_value(word_t v, logic is_last);
      word_t        ordered[$];
      word_t        tmp;
      sorted_word_t w;
      int           j;
      // values past the buffer depth are thrown away but still mark the list
      if (list_q.size() < CAP) list_q.push_back(v);
      else overflow = 1'b1;
      if (is_last) begin
        ordered = list_q;
        // plain insertion sort, equal values cannot be told apart at the output
        for (int i = 1; i < ordered.size(); i++) begin
          tmp = ordered[i];
          j   = i - 1;
          while (j >= 0 && ordered[j] > tmp) begin
            ordered[j+1] = ordered[j];
            j--;
          end
          ordered[j+1] = tmp;
        end
        foreach (ordered[k]) begin
          w.value     = ordered[k];
          w.final_res = (k == ordered.size() - 1);
          w.dropped   = overflow;
          sorted_q.push_back(w);
        end
        lists_done++;
        if (overflow) dropped_lists++;
        list_q.delete();
        overflow = 1'b0;
      end
    endfunction

    function void check_sorted(word_t v, logic f, logic d);
      sorted_word_t want;
      checked++;
      if (sorted_q.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d with nothing pending: value %0d final %0b dropped %0b",
                   checked, v, f, d);
        mismatches++;
        return;
      end
      want = sorted_q.pop_front();
      if (v !== want.value || f !== want.final_res || d !== want.dropped) begin
        if (mismatches < 10)
          $display("result %0d mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                   checked, want.value, want.final_res, want.dropped, v, f, d);
        mismatches++;
      end
    endfunction
  endclass

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  word_t value_i     = '0;
  logic  last_i      = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  word_t sorted_value_o;
  logic  final_res_o;
  logic  dropped_o;

  // shared pacing controls: a long output hold-off and gap-free stretches
  logic  hold_out = 1'b0;
  logic  no_gaps  = 1'b0;

  int    items_in = 0;
  word_t ramp;

  sort_scoreboard sb = new();

  merge_sort_engine #(
    .MAX_ITEMS(CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .dropped_o     (dropped_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t pick_value(fill_e mode, int idx);
    case (mode)
      FILL_NARROW: return word_t'($urandom_range(8)) - 4;
      FILL_EDGES: begin
        case ($urandom_range(5))
          0: return {1'b1, {(DATA_W-1){1'b0}}};
          1: return {1'b0, {(DATA_W-1){1'b1}}};
          2: return '0;
          3: return '1;
          4: return 1;
          default: return $urandom;
        endcase
      end
      FILL_RISING: begin
        ramp = (idx == 0) ? word_t'($urandom) : ramp + word_t'($urandom_range(1 << 20));
        return ramp;
      end
      FILL_FALLING: begin
        ramp = (idx == 0) ? word_t'($urandom) : ramp - word_t'($urandom_range(1 << 20));
        return ramp;
      end
      default: return $urandom;
    endcase
  endfunction

  // offers one value; returns at the accepting edge or after the idle gap; valid stays high
  // unless an idle gap follows, so the caller must lower it before any other wait
  task automatic send_value(input word_t v, input logic is_last);
    int gap;
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_value(v, is_last);
    items_in++;
    // during the output hold-off keep pushing so the input side backs up
    gap = hold_out ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // lower valid and wait until every pending sorted value has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.sorted_q.size() != 0) @(posedge clk_i);
  endtask

  // output side: check every accepted transaction, then decide next cycle's ready
  initial begin
    int gap;
    gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_sorted(sorted_value_o, final_res_o, dropped_o);
      if (hold_out) begin
        out_ready_i <= 1'b0;
      end else if (gap > 0) begin
        out_ready_i <= 1'b0;
        gap--;
      end else begin
        gap = pick_gap();
        out_ready_i <= (gap == 0);
      end
    end
  end

  // one long output hold-off while a result is offered, counted here
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (sb.checked < 40 || !out_valid_o) @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  // main stimulus
  initial begin
    int    len;
    int    list_no;
    fill_e mode;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single element, most negative value
    send_value({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    // extremes and alternating bit patterns in one list
    send_value({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
    send_value({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
    send_value('0, 1'b0);
    send_value('1, 1'b0);
    send_value(1, 1'b0);
    send_value(32'haaaa_aaaa, 1'b0);
    send_value(32'h5555_5555, 1'b1);
    // repeated values on both sides of a split
    send_value(5, 1'b0);
    send_value(5, 1'b0);
    send_value(-5, 1'b0);
    send_value(5, 1'b0);
    send_value(-5, 1'b1);
    // two values in falling order
    send_value(3, 1'b0);
    send_value(-3, 1'b1);
    // single element, most positive value
    send_value({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);

    // random lists; a full list and overflowing lists are forced at fixed positions
    list_no = 0;
    while (items_in < TARGET_ITEMS) begin
      no_gaps <= ($urandom_range(3) == 0);
      case (list_no)
        2: len = CAP;
        5: len = CAP + 1;                       // the closing value itself is discarded
        9: len = CAP + $urandom_range(2, 8);
        default: begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
            6, 7, 8:          len = $urandom_range(9, 24);
            default:          len = $urandom_range(25, CAP);
          endcase
        end
      endcase
      mode = fill_e'($urandom_range(4));
      for (int k = 0; k < len; k++)
        send_value(pick_value(mode, k), k == len - 1);
      // sender pause until the block has handed back everything
      if (list_no == 4 || $urandom_range(9) == 0) drain_results();
      list_no++;
    end

    no_gaps <= 1'b0;
    drain_results();
    repeat (50) @(posedge clk_i);

    $display("sorted %0d lists from %0d input values, %0d of them overflowing",
             sb.lists_done, items_in, sb.dropped_lists);
    $display("checked %0d sorted values, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.sorted_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, many times the slowest expected run
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== merge_sort_engine.f =====
design/mse_pkg.sv
design/merge_sort_engine.sv
design/mse_checker.sv
bench/tb_top.sv
